// File: design/tkc_pkg.sv
// Shared types, constants and round logic for the Trivium keystream core.
package tkc_pkg;

	localparam int StateBits   = 288;
	localparam int HalfBits    = 40;
	localparam int ByteBits    = 8;
	localparam int CfgIdxW     = 2;
	localparam int WarmRounds  = 4 * StateBits;
	localparam int WarmCycles  = WarmRounds / ByteBits;
	localparam int WarmCntW    = $clog2(WarmCycles);

	// Input word kinds carried on tuser.
	localparam logic CmdRestart = 1'b0;
	localparam logic CmdData    = 1'b1;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] RegKeyFirst  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegKeySecond = 2'd1;
	localparam logic [CfgIdxW-1:0] RegIvFirst   = 2'd2;
	localparam logic [CfgIdxW-1:0] RegIvSecond  = 2'd3;

	typedef logic [StateBits-1:0] state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;     // load the state from key and IV
		logic step;     // advance the state by eight rounds
		logic capture;  // register data XOR keystream byte
	} dp_cmd_t;

	typedef struct packed {
		state_t             st;
		logic [ByteBits-1:0] ks;
	} round8_t;

	// Bit s(n) of the cipher is held at vector bit n-1.
	function automatic round8_t round8(input state_t s_in);
		state_t  s;
		logic    t1;
		logic    t2;
		logic    t3;
		round8_t r;
		s = s_in;
		r.ks = '0;
		for (int i = 0; i < ByteBits; i++) begin
			t1 = s[65] ^ s[92];
			t2 = s[161] ^ s[176];
			t3 = s[242] ^ s[287];
			r.ks[i] = t1 ^ t2 ^ t3;
			t1 = t1 ^ (s[90] & s[91]) ^ s[170];
			t2 = t2 ^ (s[174] & s[175]) ^ s[263];
			t3 = t3 ^ (s[285] & s[286]) ^ s[68];
			s = {s[StateBits-2:0], t3};
			s[93] = t1;
			s[177] = t2;
		end
		r.st = s;
		return r;
	endfunction

	// Initial state: register MSB goes to the lowest numbered state bit.
	function automatic state_t init_state(
		input logic [HalfBits-1:0] kf,
		input logic [HalfBits-1:0] ksec,
		input logic [HalfBits-1:0] ivf,
		input logic [HalfBits-1:0] ivs
	);
		state_t s;
		s = '0;
		for (int j = 0; j < HalfBits; j++) begin
			s[j]       = kf[HalfBits-1-j];
			s[40 + j]  = ksec[HalfBits-1-j];
			s[93 + j]  = ivf[HalfBits-1-j];
			s[133 + j] = ivs[HalfBits-1-j];
		end
		s[287:285] = 3'b111;
		return s;
	endfunction

endpackage

// File: design/trivium_keystream_cipher_core.sv
// Trivium keystream core: data byte in, data XOR keystream byte out.
// Data word: result registered in the cycle after acceptance; one word per cycle
// sustained while m_tready stays high, set by the eight-round unrolled state update.
// Restart word: a load of the state, then warm-up steps of eight rounds each,
// 1152 rounds in all, with the input held off; it gives no result.
// Reset clears the key, IV and cipher state to zeros and empties the output.
module trivium_keystream_cipher_core import tkc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [ByteBits-1:0] s_tdata,   // [7:0] data_byte
	input  logic                s_tuser,   // [0] cmd
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [ByteBits-1:0] m_tdata,   // [7:0] result_byte
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [HalfBits-1:0] cfg_data
);

	dp_cmd_t cmd;

	tkc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_kind   (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	tkc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.data_in   (s_tdata),
		.data_out  (m_tdata)
	);

endmodule

// File: design/tkc_datapath.sv
// Datapath: key and IV registers, cipher state and output byte register.
module tkc_datapath import tkc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [HalfBits-1:0] cfg_data,
	input  dp_cmd_t             cmd,
	input  logic [ByteBits-1:0] data_in,
	output logic [ByteBits-1:0] data_out
);

	logic [HalfBits-1:0] key_first_q;
	logic [HalfBits-1:0] key_second_q;
	logic [HalfBits-1:0] iv_first_q;
	logic [HalfBits-1:0] iv_second_q;
	state_t              state_q;
	logic [ByteBits-1:0] out_q;
	round8_t             nxt;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_first_q  <= '0;
			key_second_q <= '0;
			iv_first_q   <= '0;
			iv_second_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegKeyFirst:  key_first_q  <= cfg_data;
				RegKeySecond: key_second_q <= cfg_data;
				RegIvFirst:   iv_first_q   <= cfg_data;
				RegIvSecond:  iv_second_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Eight rounds of the cipher per cycle.
	assign nxt = round8(state_q);

	// Cipher state: load from key and IV, or step by eight rounds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cmd.load) begin
			state_q <= init_state(key_first_q, key_second_q, iv_first_q, iv_second_q);
		end else if (cmd.step) begin
			state_q <= nxt.st;
		end
	end

	// Output byte register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			out_q <= data_in ^ nxt.ks;
		end
	end

	assign data_out = out_q;

endmodule

// File: design/tkc_ctrl.sv
// Controller: accepts words, sequences warm-up and holds output valid.
module tkc_ctrl import tkc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_kind,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WARM = 2'b10
	} ctrl_state_t;

	ctrl_state_t         state_q;
	logic [WarmCntW-1:0] warm_cnt_q;
	logic                out_valid_q;
	logic                accept;

	// Ready while idle and the output register is free or draining.
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd.load    = accept && (in_kind == CmdRestart);
		cmd.capture = accept && (in_kind == CmdData);
		cmd.step    = cmd.capture || (state_q == ST_WARM);
	end

	// State sequencing and warm-up count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			warm_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q    <= ST_WARM;
						warm_cnt_q <= '0;
					end
				end
				ST_WARM: begin
					if (warm_cnt_q == WarmCntW'(WarmCycles - 1)) begin
						state_q <= ST_IDLE;
					end
					warm_cnt_q <= warm_cnt_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.capture) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
